>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the scaler address unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/cfns_pkg.sv
// Shared constants, types and helper functions of the center-fill scaler address unit.
`timescale 1ns / 1ps

package cfns_pkg;

    // Display geometry and source register width.
    localparam int OUT_W      = 800;
    localparam int OUT_H      = 480;
    localparam int GUARD_ROWS = 2;
    localparam int DIM_BITS   = 12;
    localparam int COL_BITS   = 10;
    localparam int ROW_BITS   = 9;
    localparam int IDX_BITS   = 2 * DIM_BITS;
    localparam int HALF_DIV   = 2;

    // Register map.
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SRC_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_SRC_HEIGHT = CFG_IDX_BITS'(1);

    // Product width covers coordinate times span and dimension times display size.
    localparam int OW_BITS   = $clog2(OUT_W + 1);
    localparam int OH_BITS   = $clog2(OUT_H + 1);
    localparam int PROD_BITS = DIM_BITS + ((OW_BITS > OH_BITS) ? OW_BITS : OH_BITS);
    localparam int RCP_BITS  = PROD_BITS + 1;

    // Reciprocals scaled by 2**PROD_BITS, rounded down.
    localparam logic [RCP_BITS-1:0] RCP_W = RCP_BITS'((64'd1 << PROD_BITS) / OUT_W);
    localparam logic [RCP_BITS-1:0] RCP_H = RCP_BITS'((64'd1 << PROD_BITS) / OUT_H);

    // Guard rows at the bottom of the display.
    localparam bit GUARD_ON   = (GUARD_ROWS > 0) && (GUARD_ROWS < OUT_H);
    localparam int BLANK_FROM = OUT_H - GUARD_ROWS;

    // Pipeline depths.
    localparam int PIPE_LAT     = 5;
    localparam int DERIV_STAGES = 4;

    // Reset configuration and the crop window that follows from it.
    localparam int RST_SRC_W  = 1920;
    localparam int RST_SRC_H  = 1080;
    localparam longint RST_WIDE = longint'(RST_SRC_W) * OUT_H;
    localparam longint RST_TALL = longint'(RST_SRC_H) * OUT_W;
    localparam int RST_SPAN_X = (RST_WIDE > RST_TALL) ? (RST_SRC_H * OUT_W) / OUT_H : RST_SRC_W;
    localparam int RST_SPAN_Y = (RST_WIDE < RST_TALL) ? (RST_SRC_W * OUT_H) / OUT_W : RST_SRC_H;
    localparam int RST_LEFT   = (RST_SRC_W - RST_SPAN_X) / HALF_DIV;
    localparam int RST_TOP    = (RST_SRC_H - RST_SPAN_Y) / HALF_DIV;

    typedef logic [DIM_BITS-1:0]  dim_t;
    typedef logic [PROD_BITS-1:0] prod_t;
    typedef logic [IDX_BITS-1:0]  idx_t;

    // Quotient estimate by reciprocal multiply; it is exact or one too small.
    function automatic prod_t quo_estimate(prod_t num, logic [RCP_BITS-1:0] rcp);
        logic [PROD_BITS+RCP_BITS-1:0] full;
        full = (PROD_BITS + RCP_BITS)'(num) * (PROD_BITS + RCP_BITS)'(rcp);
        return full[PROD_BITS +: PROD_BITS];
    endfunction

    // One correction step: bump the estimate when the remainder reaches the divisor.
    function automatic prod_t quo_fix(prod_t num, prod_t est, prod_t den);
        prod_t rem;
        rem = num - prod_t'(est * den);
        return (rem >= den) ? est + prod_t'(1) : est;
    endfunction

endpackage

>>> rtl/core/center_fill_nearest_scaler_addr_unit.sv
// Top level of the center-fill nearest-neighbor scaler address unit.
// An accepted request runs through the five-stage pixel pipeline and done strobes its result.
// Throughput: one request per cycle while busy is low; results cannot stall.
// A configuration write raises busy while the crop window is re-derived.
// Reset (rst_n low, asynchronous) loads the 1920 x 1080 source size and its crop window
// and empties both pipelines.
`timescale 1ns / 1ps

module center_fill_nearest_scaler_addr_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [cfns_pkg::COL_BITS-1:0]        out_col,
    input  logic [cfns_pkg::ROW_BITS-1:0]        out_row,
    input  logic                                 cfg_wen,
    input  logic [cfns_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  cfns_pkg::dim_t                       cfg_data,
    output logic                                 done,
    output cfns_pkg::dim_t                       src_col,
    output cfns_pkg::dim_t                       src_row,
    output cfns_pkg::idx_t                       src_index,
    output logic                                 blank
);

    import cfns_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    dim_t src_w_reg, src_w_next;
    dim_t src_h_reg, src_h_next;

    always_comb
    begin
        src_w_next = src_w_reg;
        src_h_next = src_h_reg;
        if (cfg_wen)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  src_w_next = cfg_data;
                REG_SRC_HEIGHT: src_h_next = cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= dim_t'(RST_SRC_W);
            src_h_reg <= dim_t'(RST_SRC_H);
        end
        else
        begin
            src_w_reg <= src_w_next;
            src_h_reg <= src_h_next;
        end
    end

    // ------------------------------------------------------------------
    // Crop window derivation. Every write starts a four-stage pass: products,
    // reciprocal estimates, remainder correction, then the aspect compare
    // selects which axis is narrowed and updates the window. busy covers the
    // whole pass, but requests taken with the write or in flight may see a stale window.
    // ------------------------------------------------------------------
    logic [DERIV_STAGES-1:0] deriv_vld_reg, deriv_vld_next;

    prod_t d1_numx_reg, d1_numy_reg;
    dim_t  d1_w_reg, d1_h_reg;
    prod_t d2_numx_reg, d2_numy_reg, d2_qx_reg, d2_qy_reg;
    dim_t  d2_w_reg, d2_h_reg;
    prod_t d3_qx_reg, d3_qy_reg;
    logic  d3_wide_reg, d3_tall_reg;
    dim_t  d3_w_reg, d3_h_reg;

    dim_t crop_left_reg, crop_left_next;
    dim_t crop_top_reg, crop_top_next;
    dim_t crop_span_x_reg, crop_span_x_next;
    dim_t crop_span_y_reg, crop_span_y_next;

    assign deriv_vld_next = {deriv_vld_reg[DERIV_STAGES-2:0], cfg_wen};
    assign busy           = |deriv_vld_reg;

    // The datapath runs every cycle; only the valid bit of the last stage commits.
    always_ff @(posedge clk)
    begin
        // Height times display width, and width times display height.
        d1_numx_reg <= prod_t'(src_h_reg) * prod_t'(OUT_W);
        d1_numy_reg <= prod_t'(src_w_reg) * prod_t'(OUT_H);
        d1_w_reg    <= src_w_reg;
        d1_h_reg    <= src_h_reg;

        d2_numx_reg <= d1_numx_reg;
        d2_numy_reg <= d1_numy_reg;
        d2_qx_reg   <= quo_estimate(d1_numx_reg, RCP_H);
        d2_qy_reg   <= quo_estimate(d1_numy_reg, RCP_W);
        d2_w_reg    <= d1_w_reg;
        d2_h_reg    <= d1_h_reg;

        d3_qx_reg   <= quo_fix(d2_numx_reg, d2_qx_reg, prod_t'(OUT_H));
        d3_qy_reg   <= quo_fix(d2_numy_reg, d2_qy_reg, prod_t'(OUT_W));
        d3_wide_reg <= d2_numy_reg > d2_numx_reg;
        d3_tall_reg <= d2_numy_reg < d2_numx_reg;
        d3_w_reg    <= d2_w_reg;
        d3_h_reg    <= d2_h_reg;
    end

    // A source wider than the display aspect keeps its height and is trimmed left and right,
    // an odd column going right; a taller one keeps its width and is trimmed top and bottom,
    // an odd row going to the bottom. A matching aspect uses the whole frame.
    always_comb
    begin
        crop_left_next   = crop_left_reg;
        crop_top_next    = crop_top_reg;
        crop_span_x_next = crop_span_x_reg;
        crop_span_y_next = crop_span_y_reg;
        if (deriv_vld_reg[DERIV_STAGES-1])
        begin
            crop_left_next   = '0;
            crop_top_next    = '0;
            crop_span_x_next = d3_w_reg;
            crop_span_y_next = d3_h_reg;
            if (d3_wide_reg)
            begin
                crop_span_x_next = dim_t'(d3_qx_reg);
                crop_left_next   = dim_t'((d3_w_reg - dim_t'(d3_qx_reg)) / HALF_DIV);
            end
            else if (d3_tall_reg)
            begin
                crop_span_y_next = dim_t'(d3_qy_reg);
                crop_top_next    = dim_t'((d3_h_reg - dim_t'(d3_qy_reg)) / HALF_DIV);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deriv_vld_reg   <= '0;
            crop_left_reg   <= dim_t'(RST_LEFT);
            crop_top_reg    <= dim_t'(RST_TOP);
            crop_span_x_reg <= dim_t'(RST_SPAN_X);
            crop_span_y_reg <= dim_t'(RST_SPAN_Y);
        end
        else
        begin
            deriv_vld_reg   <= deriv_vld_next;
            crop_left_reg   <= crop_left_next;
            crop_top_reg    <= crop_top_next;
            crop_span_x_reg <= crop_span_x_next;
            crop_span_y_reg <= crop_span_y_next;
        end
    end

    // ------------------------------------------------------------------
    // Pixel pipeline.
    //   Stage 1: clamp the coordinate to the display, multiply by the span.
    //   Stage 2: reciprocal multiply gives a quotient estimate.
    //   Stage 3: remainder check corrects the estimate by one.
    //   Stage 4: add the crop origin.
    //   Stage 5: linear index as row times source width plus column.
    // ------------------------------------------------------------------
    logic                accept;
    logic [PIPE_LAT-1:0] pix_vld_reg, pix_vld_next;

    logic [COL_BITS-1:0] col_sat;
    logic [ROW_BITS-1:0] row_sat;

    prod_t p1_px_reg, p1_py_reg;
    prod_t p2_px_reg, p2_py_reg, p2_qx_reg, p2_qy_reg;
    prod_t p3_qx_reg, p3_qy_reg;
    dim_t  p4_sc_reg, p4_sr_reg;
    logic  [PIPE_LAT-2:0] blank_pipe_reg;

    dim_t  src_col_reg, src_row_reg;
    idx_t  src_index_reg;
    logic  blank_reg;

    assign accept       = start && !busy;
    assign pix_vld_next = {pix_vld_reg[PIPE_LAT-2:0], accept};

    // Coordinates past the display edge are treated as the last column or row.
    assign col_sat = (out_col > COL_BITS'(OUT_W - 1)) ? COL_BITS'(OUT_W - 1) : out_col;
    assign row_sat = (out_row > ROW_BITS'(OUT_H - 1)) ? ROW_BITS'(OUT_H - 1) : out_row;

    always_ff @(posedge clk)
    begin
        p1_px_reg <= prod_t'(col_sat) * prod_t'(crop_span_x_reg);
        p1_py_reg <= prod_t'(row_sat) * prod_t'(crop_span_y_reg);

        // The guard-row flag rides alongside the arithmetic stages.
        blank_pipe_reg <= {blank_pipe_reg[PIPE_LAT-3:0],
                           GUARD_ON && (row_sat >= ROW_BITS'(BLANK_FROM))};

        p2_px_reg <= p1_px_reg;
        p2_py_reg <= p1_py_reg;
        p2_qx_reg <= quo_estimate(p1_px_reg, RCP_W);
        p2_qy_reg <= quo_estimate(p1_py_reg, RCP_H);

        p3_qx_reg <= quo_fix(p2_px_reg, p2_qx_reg, prod_t'(OUT_W));
        p3_qy_reg <= quo_fix(p2_py_reg, p2_qy_reg, prod_t'(OUT_H));

        p4_sc_reg <= crop_left_reg + dim_t'(p3_qx_reg);
        p4_sr_reg <= crop_top_reg + dim_t'(p3_qy_reg);

        src_col_reg   <= p4_sc_reg;
        src_row_reg   <= p4_sr_reg;
        src_index_reg <= idx_t'(p4_sr_reg) * idx_t'(src_w_reg) + idx_t'(p4_sc_reg);
        blank_reg     <= blank_pipe_reg[PIPE_LAT-2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_vld_reg <= '0;
        end
        else
        begin
            pix_vld_reg <= pix_vld_next;
        end
    end

    assign done      = pix_vld_reg[PIPE_LAT-1];
    assign src_col   = src_col_reg;
    assign src_row   = src_row_reg;
    assign src_index = src_index_reg;
    assign blank     = blank_reg;

endmodule

>>> rtl/core/cfns_checker.sv
// Port-level assertions of the scaler address unit and the bind that attaches them.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfns_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [cfns_pkg::ROW_BITS-1:0]     out_row,
    input logic                              cfg_wen,
    input logic                              done,
    input logic                              blank
);

    import cfns_pkg::*;

    logic req_fire;
    logic open_row_req;

    // A request taken at this edge, and one whose row lies above the guard band.
    assign req_fire     = start && !busy;
    assign open_row_req = req_fire && (!GUARD_ON || (out_row < ROW_BITS'(BLANK_FROM)));

    // Every accepted request comes out after the fixed pipeline latency.
    `ASSERT_IMPLY(a_fixed_latency, clk, rst_n, req_fire, ##PIPE_LAT done, "request lost")

    // No result appears without a request accepted that many cycles before.
    `ASSERT_IMPLY(a_no_spurious, clk, rst_n, done, $past(req_fire, PIPE_LAT), "spurious result")

    // A register write holds off requests until the crop window is rebuilt.
    `ASSERT_NEXT(a_cfg_busy, clk, rst_n, cfg_wen, busy, "no busy after register write")

    // Rows above the guard band are never blanked.
    `ASSERT_IMPLY(a_blank_rows, clk, rst_n, open_row_req, ##PIPE_LAT !blank, "blank above guard")

endmodule

bind center_fill_nearest_scaler_addr_unit cfns_checker u_cfns_checker (.*);

>>> verif/center_fill_nearest_scaler_addr_unit_tb.sv
// Self-checking testbench for the center-fill nearest-neighbor scaler address unit.
`timescale 1ns / 1ps

module center_fill_nearest_scaler_addr_unit_tb;
    import cfns_pkg::*;

    // A run that accepts neither a request nor a result for this many cycles is hung.
    // The slowest legitimate quiet stretch is the longest sender gap that MAX_GAP
    // allows, or a pipeline drain followed by two register writes that each wait out busy.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_GAP        = 60;
    localparam int BATCHES        = 6;
    localparam int BATCH_REQUESTS = 28;
    localparam int PROBE_COUNT    = 21;

    // One source pixel address as the block reports it.
    typedef struct packed {
        dim_t col;
        dim_t row;
        idx_t index;
        logic blank;
    } src_pixel_t;

    // One row of the directed table: the source geometry to run under, the display
    // coordinate to request and, where it is obvious, the address that must come back.
    typedef struct packed {
        dim_t                  w;
        dim_t                  h;
        logic [COL_BITS-1:0]   col;
        logic [ROW_BITS-1:0]   row;
        logic                  typed;
        dim_t                  sc;
        dim_t                  sr;
        idx_t                  idx;
        logic                  blk;
    } geometry_probe_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [COL_BITS-1:0]     out_col;
    logic [ROW_BITS-1:0]     out_row;
    logic                    cfg_wen;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    dim_t                    cfg_data;
    logic                    done;
    dim_t                    src_col;
    dim_t                    src_row;
    idx_t                    src_index;
    logic                    blank;

    // Predicted source geometry and the crop window that follows from it.
    dim_t geo_w;
    dim_t geo_h;
    dim_t win_left;
    dim_t win_top;
    dim_t win_span_x;
    dim_t win_span_y;

    // Addresses owed by the block, oldest first.
    src_pixel_t pending_pixels[$];
    int         mismatch_count = 0;
    int         quiet_cycles = 0;

    // Directed table. The first rows run under the reset geometry of 1920 x 1080,
    // which crops 60 columns off each side and keeps all rows. They cover the corners,
    // coordinates past the display edge that must saturate, and the last rows around
    // the guard band. Then come the identity geometry, a matching aspect ratio with no
    // crop, a tall frame that is cropped top and bottom, the register extremes, zero
    // sizes on one or both axes, and finally the reset geometry again.
    geometry_probe_t directed_probes [PROBE_COUNT] = '{
        '{1920, 1080,    0,   0, 1,   60,    0,      60, 0},
        '{1920, 1080,  799, 479, 1, 1857, 1077, 2069697, 1},
        '{1920, 1080, 1023, 511, 1, 1857, 1077, 2069697, 1},
        '{1920, 1080,  800, 480, 1, 1857, 1077, 2069697, 1},
        '{1920, 1080,  799,   0, 1, 1857,    0,    1857, 0},
        '{1920, 1080,    0, 477, 1,   60, 1073, 2060220, 0},
        '{1920, 1080,    0, 478, 1,   60, 1075, 2064060, 1},
        '{1920, 1080,  512, 256, 0,    0,    0,       0, 0},
        '{ 800,  480,    5,   7, 1,    5,    7,    5605, 0},
        '{ 800,  480,  799, 479, 1,  799,  479,  383999, 1},
        '{1600,  960,  400, 240, 0,    0,    0,       0, 0},
        '{ 640,  480,  320, 240, 0,    0,    0,       0, 0},
        '{4095, 4095,    0,   0, 0,    0,    0,       0, 0},
        '{4095, 4095,  799, 479, 0,    0,    0,       0, 0},
        '{4095,    1,  799, 479, 0,    0,    0,       0, 0},
        '{   1, 4095,  799, 479, 0,    0,    0,       0, 0},
        '{   0,    0,  799, 479, 1,    0,    0,       0, 1},
        '{   0,  100,  400, 200, 0,    0,    0,       0, 0},
        '{ 100,    0,  400, 200, 0,    0,    0,       0, 0},
        '{   1,    1, 1023, 511, 0,    0,    0,       0, 0},
        '{1920, 1080,  341, 170, 0,    0,    0,       0, 0}
    };

    center_fill_nearest_scaler_addr_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .out_col   (out_col),
        .out_row   (out_row),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .src_col   (src_col),
        .src_row   (src_row),
        .src_index (src_index),
        .blank     (blank)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Recompute the crop window from the predicted source size. The frame is compared
    // with the display aspect by cross-multiplying; the axis that is too long is cut
    // down to the display aspect by truncating division and centered, with the odd
    // leftover pixel going to the far side. A zero size leaves a zero span on its axis.
    function automatic void derive_crop_window();
        bit [63:0] w;
        bit [63:0] h;
        bit [63:0] wide;
        bit [63:0] tall;
        bit [63:0] span;
        w    = 64'(geo_w);
        h    = 64'(geo_h);
        wide = w * 64'(OUT_H);
        tall = h * 64'(OUT_W);
        win_left   = '0;
        win_top    = '0;
        win_span_x = geo_w;
        win_span_y = geo_h;
        if (wide > tall)
        begin
            span       = (h * 64'(OUT_W)) / 64'(OUT_H);
            win_span_x = dim_t'(span);
            win_left   = dim_t'((w - span) / 64'(HALF_DIV));
        end
        else if (wide < tall)
        begin
            span       = (w * 64'(OUT_H)) / 64'(OUT_W);
            win_span_y = dim_t'(span);
            win_top    = dim_t'((h - span) / 64'(HALF_DIV));
        end
    endfunction

    // Nearest-neighbor source pixel for one display coordinate. Coordinates past the
    // display edge are clamped to the last column or row, so a clamped row also falls
    // in the guard band. Guard rows still carry their mapped address.
    function automatic src_pixel_t map_display_pixel(logic [COL_BITS-1:0] c,
                                                     logic [ROW_BITS-1:0] r);
        bit [63:0]  col;
        bit [63:0]  row;
        src_pixel_t px;
        col = 64'(c);
        row = 64'(r);
        if (col > 64'(OUT_W - 1))
            col = 64'(OUT_W - 1);
        if (row > 64'(OUT_H - 1))
            row = 64'(OUT_H - 1);
        px.col   = dim_t'(64'(win_left) + (col * 64'(win_span_x)) / 64'(OUT_W));
        px.row   = dim_t'(64'(win_top) + (row * 64'(win_span_y)) / 64'(OUT_H));
        px.index = idx_t'(64'(px.row) * 64'(geo_w) + 64'(px.col));
        px.blank = (GUARD_ROWS > 0) && (GUARD_ROWS < OUT_H)
                   && (row >= 64'(OUT_H - GUARD_ROWS));
        return px;
    endfunction

    // Mostly any legal size, with the register extremes, zero and tiny frames mixed in.
    function automatic dim_t pick_dimension();
        case ($urandom_range(19))
            0:       return dim_t'(0);
            1:       return dim_t'(1);
            2:       return dim_t'(4095);
            3:       return dim_t'($urandom_range(16, 2));
            default: return dim_t'($urandom_range(4095, 1));
        endcase
    endfunction

    // Present one request from a falling edge and hold it until the block takes it.
    // The caller passes a typed-in address, or asks for the predicted one.
    task automatic issue_request(logic [COL_BITS-1:0] c, logic [ROW_BITS-1:0] r,
                                 bit use_typed, src_pixel_t typed_px);
        out_col <= c;
        out_row <= r;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (use_typed)
            pending_pixels.push_back(typed_px);
        else
            pending_pixels.push_back(map_display_pixel(c, r));
        @(negedge clk);
    endtask

    // Let the sender go quiet for a random number of cycles: each cycle is idle with
    // the given percentage. The coordinate lines carry junk while start is low.
    task automatic sender_gap(int unsigned idle_pct);
        int n;
        n = 0;
        while (n < MAX_GAP && $urandom_range(99) < idle_pct)
            n++;
        if (n > 0)
        begin
            start   <= 1'b0;
            out_col <= COL_BITS'($urandom);
            out_row <= ROW_BITS'($urandom);
            repeat (n) @(negedge clk);
        end
    endtask

    // Write one register from a falling edge, then wait for the crop window to settle.
    task automatic write_register(logic [CFG_IDX_BITS-1:0] index, dim_t value);
        cfg_wen   <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        if (index == REG_SRC_WIDTH)
            geo_w = value;
        else
            geo_h = value;
        derive_crop_window();
        @(negedge clk);
        cfg_wen <= 1'b0;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Stop sending, let every owed address come back, then change the source size.
    task automatic set_geometry(dim_t w, dim_t h);
        start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        @(negedge clk);
        write_register(REG_SRC_WIDTH, w);
        write_register(REG_SRC_HEIGHT, h);
    endtask

    // Every strobed result must match the oldest owed address, field by field.
    always @(posedge clk)
    begin
        src_pixel_t want;
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected result col %0d row %0d index %0d blank %0b",
                         $time, src_col, src_row, src_index, blank);
                mismatch_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (src_col !== want.col)
                begin
                    $display("%0t: src_col expected %0d got %0d", $time, want.col, src_col);
                    mismatch_count++;
                end
                if (src_row !== want.row)
                begin
                    $display("%0t: src_row expected %0d got %0d", $time, want.row, src_row);
                    mismatch_count++;
                end
                if (src_index !== want.index)
                begin
                    $display("%0t: src_index expected %0d got %0d",
                             $time, want.index, src_index);
                    mismatch_count++;
                end
                if (blank !== want.blank)
                begin
                    $display("%0t: blank expected %0b got %0b", $time, want.blank, blank);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: any accepted request or result counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("center_fill_nearest_scaler_addr_unit_tb failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned     idle_pct [3];
        geometry_probe_t probe;
        dim_t            w;
        dim_t            h;
        int unsigned     k;
        logic [COL_BITS-1:0] c;
        logic [ROW_BITS-1:0] r;

        // Phases of sender behavior: back to back, mostly idle, lightly idle.
        idle_pct = '{0, 86, 25};

        rst_n          = 1'b0;
        start          = 1'b0;
        out_col        = '0;
        out_row        = '0;
        cfg_wen        = 1'b0;
        cfg_index      = REG_SRC_WIDTH;
        cfg_data       = '0;

        // The block comes out of reset with the 1920 x 1080 source size.
        geo_w = dim_t'(RST_SRC_W);
        geo_h = dim_t'(RST_SRC_H);
        derive_crop_window();

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: each row switches geometry only when it differs from the last.
        foreach (directed_probes[i])
        begin
            probe = directed_probes[i];
            if (probe.w != geo_w || probe.h != geo_h)
                set_geometry(probe.w, probe.h);
            issue_request(probe.col, probe.row, probe.typed,
                          '{probe.sc, probe.sr, probe.idx, probe.blk});
        end

        // Random part: in each sender phase, several source sizes, some of them with
        // exactly the display aspect, each followed by a batch of random coordinates.
        // Coordinates lean toward the guard band and past the display edge now and then.
        foreach (idle_pct[p])
        begin
            for (int b = 0; b < BATCHES; b++)
            begin
                if ($urandom_range(7) == 0)
                begin
                    k = $urandom_range(819, 1);
                    w = dim_t'(5 * k);
                    h = dim_t'(3 * k);
                end
                else
                begin
                    w = pick_dimension();
                    h = pick_dimension();
                end
                set_geometry(w, h);
                for (int n = 0; n < BATCH_REQUESTS; n++)
                begin
                    if ($urandom_range(9) == 0)
                        c = COL_BITS'($urandom_range(1023, OUT_W));
                    else
                        c = COL_BITS'($urandom_range(OUT_W - 1, 0));
                    case ($urandom_range(9))
                        0:       r = ROW_BITS'($urandom_range(511, OUT_H));
                        1:       r = ROW_BITS'($urandom_range(OUT_H - 1, OUT_H - 10));
                        default: r = ROW_BITS'($urandom_range(OUT_H - 1, 0));
                    endcase
                    issue_request(c, r, 1'b0, '0);
                    sender_gap(idle_pct[p]);
                end
            end
        end

        // Drain, then give the pipeline time to show any stray result.
        start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);

        if (mismatch_count == 0)
            $display("center_fill_nearest_scaler_addr_unit_tb passed");
        else
            $display("center_fill_nearest_scaler_addr_unit_tb failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/cfns_pkg.sv
rtl/core/center_fill_nearest_scaler_addr_unit.sv
rtl/core/cfns_checker.sv
verif/center_fill_nearest_scaler_addr_unit_tb.sv
